// ===== hw/rtl/pfe_pkg.sv =====
// Shared types and constants of the Playfair encryptor.
// No dependencies; every other file of the block but pfe_ram imports this package.
package pfe_pkg;

   localparam int LETTER_W = 5;

   typedef logic [LETTER_W-1:0] letter_type;

   // Item kinds carried on the request side
   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_FINISH = 2'd1,
      OP_PLAIN  = 2'd2,
      OP_END    = 2'd3
   } op_type;

   localparam letter_type LTR_A       = 5'd0;
   localparam letter_type LTR_I       = 5'd8;
   localparam letter_type LTR_J       = 5'd9;
   localparam letter_type LTR_X       = 5'd23;
   localparam letter_type LTR_Z       = 5'd25;
   localparam letter_type NUM_LETTERS = 5'd26;
   localparam letter_type NUM_CELLS   = 5'd25;

   // One unit of work from the front end to the back end
   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       pair;
      logic       eom;
      logic       not_ready;
   } job_type;

endpackage

// ===== hw/rtl/pfe_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/pfe_front.sv =====
// Front end: accepts items, builds the key square, forms digraphs.
// Depends on pfe_pkg; drives the write ports of both RAMs and the job queue.
module pfe_front
   import pfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  letter_type req_letter,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job,
   output logic       ram_we,
   output letter_type key_wr_addr,
   output letter_type key_wr_data,
   output letter_type pos_wr_addr,
   output letter_type pos_wr_data
);

   typedef enum logic [1:0] {
      FS_RUN  = 2'b01,
      FS_FILL = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [NUM_LETTERS-1:0] used_ff, used_in;
   letter_type fill_cnt_ff, fill_cnt_in;
   letter_type fill_ltr_ff, fill_ltr_in;
   logic       sq_ready_ff, sq_ready_in;
   letter_type held_ff, held_in;
   logic       held_vld_ff, held_vld_in;

   op_type     op;
   letter_type ltr;
   letter_type cand;
   logic       fire;
   logic       is_letter;
   logic       cand_ok;
   logic       place;

   assign op        = op_type'(req_op);
   assign ltr       = (req_letter == LTR_J) ? LTR_I : req_letter;
   assign is_letter = ltr < NUM_LETTERS;
   assign req_ready = (state_ff == FS_RUN) && !q_full;
   assign fire      = req_valid && req_ready;

   assign cand    = (state_ff == FS_FILL) ? fill_ltr_ff : ltr;
   assign cand_ok = (state_ff == FS_FILL) ? (fill_ltr_ff != LTR_J)
                  : (fire && op == OP_KEY && !sq_ready_ff && is_letter);
   assign place   = cand_ok && !used_ff[cand] && (fill_cnt_ff < NUM_CELLS);

   // Key square cell and letter position are written together
   assign ram_we      = place;
   assign key_wr_addr = fill_cnt_ff;
   assign key_wr_data = cand;
   assign pos_wr_addr = cand;
   assign pos_wr_data = fill_cnt_ff;

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      fill_cnt_in = fill_cnt_ff;
      fill_ltr_in = fill_ltr_ff;
      sq_ready_in = sq_ready_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      q_push      = 1'b0;
      q_job       = '0;

      if (place) begin
         used_in[cand] = 1'b1;
         fill_cnt_in   = fill_cnt_ff + 5'd1;
      end

      case (state_ff)
         FS_FILL: begin
            // Walk the alphabet once, then the square is complete
            fill_ltr_in = fill_ltr_ff + 5'd1;
            if (fill_ltr_ff == LTR_Z) begin
               sq_ready_in = 1'b1;
               state_in    = FS_RUN;
            end
         end
         FS_RUN: begin
            if (fire) begin
               case (op)
                  OP_FINISH: begin
                     if (!sq_ready_ff) begin
                        state_in    = FS_FILL;
                        fill_ltr_in = LTR_A;
                     end
                  end
                  OP_PLAIN: begin
                     if (is_letter) begin
                        if (!sq_ready_ff) begin
                           q_push          = 1'b1;
                           q_job.not_ready = 1'b1;
                        end else if (!held_vld_ff) begin
                           held_in     = ltr;
                           held_vld_in = 1'b1;
                        end else if (held_ff == ltr) begin
                           // Split a doubled letter; it still starts the next pair
                           q_push       = 1'b1;
                           q_job.pair   = 1'b1;
                           q_job.first  = held_ff;
                           q_job.second = LTR_X;
                        end else begin
                           q_push       = 1'b1;
                           q_job.pair   = 1'b1;
                           q_job.first  = held_ff;
                           q_job.second = ltr;
                           held_vld_in  = 1'b0;
                        end
                     end
                  end
                  OP_END: begin
                     q_push          = 1'b1;
                     q_job.eom       = 1'b1;
                     q_job.not_ready = !sq_ready_ff;
                     q_job.pair      = sq_ready_ff && held_vld_ff;
                     q_job.first     = held_ff;
                     q_job.second    = LTR_Z;
                     held_vld_in     = 1'b0;
                     held_in         = LTR_A;
                  end
                  default: begin
                     // Key letters are placed above
                  end
               endcase
            end
         end
         default: begin
            state_in = FS_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_RUN;
         used_ff     <= '0;
         fill_cnt_ff <= '0;
         fill_ltr_ff <= '0;
         sq_ready_ff <= 1'b0;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         fill_cnt_ff <= fill_cnt_in;
         fill_ltr_ff <= fill_ltr_in;
         sq_ready_ff <= sq_ready_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
      end
   end

endmodule

// ===== hw/rtl/pfe_queue.sv =====
// Two-entry job queue between front end and back end.
// Depends on pfe_pkg for the job type.
module pfe_queue
   import pfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   job_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/pfe_back.sv =====
// Back end: looks up cell positions, applies the Playfair rules, holds the result.
// Depends on pfe_pkg; reads both RAMs and pops the job queue.
module pfe_back
   import pfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       pos_rd_en,
   output letter_type pos_rd_addr_a,
   output letter_type pos_rd_addr_b,
   input  letter_type pos_rd_data_a,
   input  letter_type pos_rd_data_b,
   output logic       key_rd_en,
   output letter_type key_rd_addr_a,
   output letter_type key_rd_addr_b,
   input  letter_type key_rd_data_a,
   input  letter_type key_rd_data_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output letter_type rsp_first,
   output letter_type rsp_second,
   output logic       rsp_pair,
   output logic       rsp_eom,
   output logic       rsp_not_ready
);

   typedef enum logic [2:0] {
      BS_IDLE = 3'b001,
      BS_POS  = 3'b010,
      BS_KEY  = 3'b100
   } back_state_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } cell_type;

   // Split a cell index 0..24 into row and column
   function automatic cell_type to_cell(letter_type p);
      cell_type c;
      logic [2:0] r;
      letter_type base;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      base  = {r, 2'b00} + {2'b00, r};
      c.row = r;
      c.col = 3'(p - base);
      return c;
   endfunction

   function automatic letter_type from_cell(logic [2:0] r, logic [2:0] c);
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
   endfunction

   function automatic logic [2:0] wrap_inc(logic [2:0] v);
      return (v == 3'd4) ? 3'd0 : v + 3'd1;
   endfunction

   back_state_type state_ff, state_in;
   logic           eom_ff, eom_in;
   logic           out_vld_ff, out_vld_in;
   letter_type     first_ff, first_in;
   letter_type     second_ff, second_in;
   logic           pair_ff, pair_in;
   logic           eom_out_ff, eom_out_in;
   logic           nr_ff, nr_in;

   cell_type       c1, c2;
   logic           out_free;

   assign out_free      = !out_vld_ff || rsp_ready;
   assign c1            = to_cell(pos_rd_data_a);
   assign c2            = to_cell(pos_rd_data_b);
   assign pos_rd_addr_a = head_job.first;
   assign pos_rd_addr_b = head_job.second;

   always_comb begin
      state_in      = state_ff;
      eom_in        = eom_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      first_in      = first_ff;
      second_in     = second_ff;
      pair_in       = pair_ff;
      eom_out_in    = eom_out_ff;
      nr_in         = nr_ff;
      q_pop         = 1'b0;
      pos_rd_en     = 1'b0;
      key_rd_en     = 1'b0;
      key_rd_addr_a = from_cell(c1.row, c2.col);
      key_rd_addr_b = from_cell(c2.row, c1.col);

      if (c1.row == c2.row) begin
         key_rd_addr_a = from_cell(c1.row, wrap_inc(c1.col));
         key_rd_addr_b = from_cell(c2.row, wrap_inc(c2.col));
      end else if (c1.col == c2.col) begin
         key_rd_addr_a = from_cell(wrap_inc(c1.row), c1.col);
         key_rd_addr_b = from_cell(wrap_inc(c2.row), c2.col);
      end

      case (state_ff)
         BS_IDLE: begin
            if (!q_empty) begin
               if (head_job.pair) begin
                  q_pop     = 1'b1;
                  pos_rd_en = 1'b1;
                  eom_in    = head_job.eom;
                  state_in  = BS_POS;
               end else if (out_free) begin
                  // Status-only result goes straight to the output register
                  q_pop      = 1'b1;
                  out_vld_in = 1'b1;
                  first_in   = LTR_A;
                  second_in  = LTR_A;
                  pair_in    = 1'b0;
                  eom_out_in = head_job.eom;
                  nr_in      = head_job.not_ready;
               end
            end
         end
         BS_POS: begin
            key_rd_en = 1'b1;
            state_in  = BS_KEY;
         end
         BS_KEY: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               first_in   = key_rd_data_a;
               second_in  = key_rd_data_b;
               pair_in    = 1'b1;
               eom_out_in = eom_ff;
               nr_in      = 1'b0;
               state_in   = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      eom_ff     <= eom_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      pair_ff    <= pair_in;
      eom_out_ff <= eom_out_in;
      nr_ff      <= nr_in;
      if (reset) begin
         state_ff   <= BS_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_first     = first_ff;
   assign rsp_second    = second_ff;
   assign rsp_pair      = pair_ff;
   assign rsp_eom       = eom_out_ff;
   assign rsp_not_ready = nr_ff;

endmodule

// ===== hw/rtl/playfair_encryptor.sv =====
// Top level of the Playfair encryptor: front end, job queue, back end, two RAMs.
// Depends on pfe_pkg, pfe_ram, pfe_front, pfe_queue and pfe_back.
//
// Stream in key letters (kind 0), then one finish item (kind 1), then
// plaintext letters (kind 2) and an end-of-message item (kind 3). Letter
// codes are a=0..z=25; j counts as i; codes 26..31 are spaces and give
// nothing. Key letters go into the 5x5 square in first-seen order; the finish
// item fills the rest alphabetically, skipping j, and no item is accepted
// while it does so. Plaintext pairs into digraphs: a doubled letter is split
// by x and the repeated letter starts the next pair; a lone letter at the
// end is paired with z. Each digraph gives one transfer carrying the two
// ciphertext letters with pair_valid set. Plaintext before the square is
// finished gives a transfer with not_ready set; end of message always gives
// one transfer with tlast set. Key and plaintext items are taken one per
// cycle while the two-entry job queue has room; the back end works on one
// digraph at a time in three steps (position lookup, key-square lookup,
// result register) and, while idle, passes one status-only transfer per
// cycle while the receiver takes them. The result register lets the next
// digraph be worked on while one still waits for rsp_tready.
module playfair_encryptor
   import pfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] cipher_first, [9:5] cipher_second, [15:10] zero
   output logic [1:0]  rsp_tuser,   // [0] pair_valid, [1] not_ready
   output logic        rsp_tlast    // end_of_message
);

   job_type    push_job, head_job;
   logic       q_push, q_pop, q_empty, q_full;
   logic       ram_we;
   letter_type key_wr_addr, key_wr_data, pos_wr_addr, pos_wr_data;
   logic       pos_rd_en, key_rd_en;
   letter_type pos_rd_addr_a, pos_rd_addr_b, pos_rd_data_a, pos_rd_data_b;
   letter_type key_rd_addr_a, key_rd_addr_b, key_rd_data_a, key_rd_data_b;
   letter_type rsp_first, rsp_second;
   logic       rsp_pair, rsp_eom, rsp_not_ready;

   // Classify items, build the square, form digraphs
   pfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_letter  (req_tdata[LETTER_W-1:0]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .ram_we      (ram_we),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data),
      .pos_wr_addr (pos_wr_addr),
      .pos_wr_data (pos_wr_data)
   );

   // Decouple the two halves so each can stall on its own
   pfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Letter -> cell index
   pfe_ram #(
      .WIDTH (5),
      .DEPTH (26)
   ) u_pos_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (pos_wr_addr),
      .wr_data   (pos_wr_data),
      .rd_en     (pos_rd_en),
      .rd_addr_a (pos_rd_addr_a),
      .rd_addr_b (pos_rd_addr_b),
      .rd_data_a (pos_rd_data_a),
      .rd_data_b (pos_rd_data_b)
   );

   // Cell index -> letter
   pfe_ram #(
      .WIDTH (5),
      .DEPTH (25)
   ) u_key_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (key_wr_addr),
      .wr_data   (key_wr_data),
      .rd_en     (key_rd_en),
      .rd_addr_a (key_rd_addr_a),
      .rd_addr_b (key_rd_addr_b),
      .rd_data_a (key_rd_data_a),
      .rd_data_b (key_rd_data_b)
   );

   // Encrypt and hold the result for the response side
   pfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .pos_rd_en     (pos_rd_en),
      .pos_rd_addr_a (pos_rd_addr_a),
      .pos_rd_addr_b (pos_rd_addr_b),
      .pos_rd_data_a (pos_rd_data_a),
      .pos_rd_data_b (pos_rd_data_b),
      .key_rd_en     (key_rd_en),
      .key_rd_addr_a (key_rd_addr_a),
      .key_rd_addr_b (key_rd_addr_b),
      .key_rd_data_a (key_rd_data_a),
      .key_rd_data_b (key_rd_data_b),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_first     (rsp_first),
      .rsp_second    (rsp_second),
      .rsp_pair      (rsp_pair),
      .rsp_eom       (rsp_eom),
      .rsp_not_ready (rsp_not_ready)
   );

   assign rsp_tdata = {6'd0, rsp_second, rsp_first};
   assign rsp_tuser = {rsp_not_ready, rsp_pair};
   assign rsp_tlast = rsp_eom;

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("job queue popped while empty");

   // Front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job queue pushed while full");

   // A digraph result never also flags an unfinished square
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("pair_valid and not_ready both set");

   // Status-only results carry zero letters
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[9:0] == 10'd0))
      else $error("cipher letters nonzero without a pair");

endmodule

// ===== tb/pfe_digraph_checker.sv =====
// Checker for the Playfair encryptor: watches both stream channels, predicts each digraph
// and compares it with the transfers on the result side.
// Depends on pfe_pkg for letter codes, item kinds and the result record.
`timescale 1ns / 100ps

module pfe_digraph_checker
   import pfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [4:0] cipher_first, [9:5] cipher_second, [15:10] zero
   input  logic [1:0]  rsp_tuser,   // [0] pair_valid, [1] not_ready
   input  logic        rsp_tlast,   // end_of_message
   output int          open_results,
   output int          fault_count
);

   letter_type square_cell [0:24];
   letter_type cell_of     [0:25];
   logic       placed      [0:25];
   letter_type fill;
   logic       square_done;
   letter_type held;
   logic       held_ok;

   job_type cipher_queue [$];
   int      faults = 0;

   function automatic void place_in_square(letter_type l);
      if (l < NUM_LETTERS && !placed[l] && fill < NUM_CELLS) begin
         square_cell[fill] = l;
         cell_of[l]        = fill;
         placed[l]         = 1'b1;
         fill              = fill + 1'b1;
      end
   endfunction

   function automatic job_type cipher_digraph(letter_type a, letter_type b);
      int      r1, c1, r2, c2, q1, q2;
      job_type res;
      r1 = int'(cell_of[a]) / 5;
      c1 = int'(cell_of[a]) % 5;
      r2 = int'(cell_of[b]) / 5;
      c2 = int'(cell_of[b]) % 5;
      if (r1 == r2) begin
         q1 = r1 * 5 + (c1 + 1) % 5;
         q2 = r2 * 5 + (c2 + 1) % 5;
      end else if (c1 == c2) begin
         q1 = ((r1 + 1) % 5) * 5 + c1;
         q2 = ((r2 + 1) % 5) * 5 + c2;
      end else begin
         q1 = r1 * 5 + c2;
         q2 = r2 * 5 + c1;
      end
      res        = '0;
      res.first  = square_cell[q1];
      res.second = square_cell[q2];
      res.pair   = 1'b1;
      return res;
   endfunction

   // advance the square and the held letter by one item; flag a result if one is due
   task automatic encipher_item(input op_type op, input letter_type raw,
                                output bit has, output job_type res);
      letter_type l;
      res = '0;
      has = 1'b0;
      l   = (raw == LTR_J) ? LTR_I : raw;
      case (op)
         OP_KEY: begin
            if (!square_done) place_in_square(l);
         end
         OP_FINISH: begin
            if (!square_done) begin
               for (int c = 0; c < 26; c++)
                  if (letter_type'(c) != LTR_J) place_in_square(letter_type'(c));
               square_done = 1'b1;
            end
         end
         OP_PLAIN: begin
            if (l < NUM_LETTERS) begin
               if (!square_done) begin
                  has           = 1'b1;
                  res.not_ready = 1'b1;
               end else if (!held_ok) begin
                  held    = l;
                  held_ok = 1'b1;
               end else if (held == l) begin
                  has = 1'b1;
                  res = cipher_digraph(held, LTR_X);
               end else begin
                  has     = 1'b1;
                  res     = cipher_digraph(held, l);
                  held_ok = 1'b0;
               end
            end
         end
         default: begin
            has = 1'b1;
            if (!square_done) res.not_ready = 1'b1;
            else if (held_ok) res = cipher_digraph(held, LTR_Z);
            res.eom = 1'b1;
            held_ok = 1'b0;
            held    = LTR_A;
         end
      endcase
   endtask

   task automatic note_fault(string why, job_type want, job_type got);
      faults++;
      if (faults <= 10)
         $display("%0t pfe check: %s: expected first=%0d second=%0d pair=%b eom=%b nr=%b, got first=%0d second=%0d pair=%b eom=%b nr=%b",
                  $realtime, why, want.first, want.second, want.pair, want.eom, want.not_ready,
                  got.first, got.second, got.pair, got.eom, got.not_ready);
   endtask

   always @(posedge clock) begin : watch
      job_type got, want, fresh;
      bit      has;
      if (reset) begin
         for (int k = 0; k < 26; k++) placed[k] = 1'b0;
         fill        = '0;
         square_done = 1'b0;
         held        = LTR_A;
         held_ok     = 1'b0;
         cipher_queue.delete();
      end else begin
         // results first: a transfer on the result side never belongs to this edge's request
         if (rsp_tvalid && rsp_tready) begin
            got.first     = rsp_tdata[4:0];
            got.second    = rsp_tdata[9:5];
            got.pair      = rsp_tuser[0];
            got.not_ready = rsp_tuser[1];
            got.eom       = rsp_tlast;
            if (cipher_queue.size() == 0) begin
               note_fault("result with nothing expected", '0, got);
            end else begin
               want = cipher_queue.pop_front();
               if (got.first !== want.first || got.second !== want.second ||
                   got.pair !== want.pair || got.eom !== want.eom ||
                   got.not_ready !== want.not_ready)
                  note_fault("field mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            encipher_item(op_type'(req_tuser), letter_type'(req_tdata[4:0]), has, fresh);
            if (has) cipher_queue.push_back(fresh);
         end
      end
      open_results <= cipher_queue.size();
      fault_count  <= faults;
   end

endmodule

// ===== tb/tb_playfair_encryptor.sv =====
// Top of the Playfair encryptor testbench: clock, reset, stimulus, result-side stalls, verdict.
// Depends on pfe_pkg, playfair_encryptor and pfe_digraph_checker.
`timescale 1ns / 100ps

module tb_playfair_encryptor;
   import pfe_pkg::*;

   localparam int         CYCLE_LIMIT = 200000;
   localparam logic [4:0] CODE_SPACE  = 5'd26;
   localparam logic [4:0] CODE_TOP    = 5'd31;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [4:0] letter, [7:5] zero
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [4:0] cipher_first, [9:5] cipher_second, [15:10] zero
   logic [1:0]  rsp_tuser;        // [0] pair_valid, [1] not_ready
   logic        rsp_tlast;        // end_of_message

   int open_results;
   int fault_count;
   int cycle_count = 0;
   int send_idle   = 34;   // percent of cycles the sender holds off
   int recv_stall  = 53;   // percent of cycles the receiver drops tready

   always #1 clock = ~clock;

   playfair_encryptor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pfe_digraph_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .open_results (open_results),
      .fault_count  (fault_count)
   );

   // result side: drop tready at random at the current stall rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
   end

   // watchdog: end the run with errors once the cycle limit is reached
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_playfair_encryptor: done, errors");
         $finish;
      end
   end

   // Present one item and hold it until the transfer. Idle cycles go in front of the
   // item, so valid is lowered or raised once per step and never both.
   task automatic send_letter(op_type op, logic [4:0] letter);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, letter};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off the sender until every expected result has come back. The checker's
   // count is registered, so wait for it to update first.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
   endtask

   // letter for plaintext: lean on j and i so the j-as-i folding shows up in pairs
   function automatic logic [4:0] plain_letter();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return LTR_J;
      if (roll < 14) return LTR_I;
      if (roll < 20) return LTR_X;
      return 5'($urandom_range(0, 25));
   endfunction

   // Random plaintext stream with messages closed at random, mixed with spaces, bad codes
   // and key and finish items after the square is done. Every item sent counts toward the goal.
   task automatic plaintext_traffic(int goal);
      int         counted;
      int         roll;
      logic [4:0] prev;
      logic [4:0] pick;
      counted = 0;
      prev    = LTR_A;
      while (counted < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 68) begin
            // repeat the last letter now and then to split doubled letters with x
            pick = ($urandom_range(0, 4) == 0) ? prev : plain_letter();
            send_letter(OP_PLAIN, pick);
            prev = pick;
         end else if (roll < 78) begin
            send_letter(OP_END, 5'($urandom_range(0, 31)));
         end else if (roll < 88) begin
            send_letter(OP_PLAIN, 5'($urandom_range(26, 31)));
         end else if (roll < 95) begin
            send_letter(OP_KEY, 5'($urandom_range(0, 31)));
         end else begin
            send_letter(OP_FINISH, 5'($urandom_range(0, 31)));
         end
         counted++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plaintext, a space and end of message before the square exists
      send_letter(OP_PLAIN, LTR_A);
      send_letter(OP_PLAIN, CODE_SPACE);
      send_letter(OP_END, LTR_Z);
      // key: j folds to i, so the following i is a repeat; spaces and bad codes drop out
      send_letter(OP_KEY, LTR_J);
      send_letter(OP_KEY, LTR_I);
      send_letter(OP_KEY, CODE_TOP);
      send_letter(OP_KEY, CODE_SPACE);
      send_letter(OP_KEY, LTR_Z);
      send_letter(OP_KEY, LTR_A);
      send_letter(OP_PLAIN, LTR_Z);
      // random rest of the key, then fill the square
      repeat ($urandom_range(2, 12)) send_letter(OP_KEY, 5'($urandom_range(0, 31)));
      send_letter(OP_FINISH, LTR_A);
      // a second finish and a late key letter are ignored once the square is done
      send_letter(OP_FINISH, CODE_TOP);
      send_letter(OP_KEY, LTR_X);
      // close with nothing held
      send_letter(OP_END, LTR_A);
      // doubled a: (a, x) and a stays held, then a pairs with x
      send_letter(OP_PLAIN, LTR_A);
      send_letter(OP_PLAIN, LTR_A);
      send_letter(OP_PLAIN, LTR_X);
      // doubled x gives (x, x); the held x closes with z
      send_letter(OP_PLAIN, LTR_X);
      send_letter(OP_PLAIN, LTR_X);
      send_letter(OP_END, CODE_TOP);
      // a lone z closes as (z, z)
      send_letter(OP_PLAIN, LTR_Z);
      send_letter(OP_END, LTR_A);
      // j then i counts as a doubled letter; a bad code in between is skipped
      send_letter(OP_PLAIN, LTR_J);
      send_letter(OP_PLAIN, CODE_TOP);
      send_letter(OP_PLAIN, LTR_I);
      send_letter(OP_END, LTR_A);

      plaintext_traffic(530);
      drain_results();

      send_idle  = 53;
      recv_stall = 34;
      plaintext_traffic(530);

      send_idle  = 0;
      recv_stall = 0;
      plaintext_traffic(540);

      drain_results();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && open_results == 0) begin
         $display("tb_playfair_encryptor: done, clean");
      end else begin
         $display("tb_playfair_encryptor: done, errors");
      end
      $finish;
   end

endmodule
